// File: rtl/core/aging_keyed_slot_table_core_assert.svh
// Assertion macros shared by the slot table RTL.
`ifndef AGING_KEYED_SLOT_TABLE_CORE_ASSERT_SVH
`define AGING_KEYED_SLOT_TABLE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define AKST_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("slot table assertion failed");
// Condition must never be true outside reset.
`define AKST_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("slot table forbidden condition seen");
`else
`define AKST_ASSERT(label, prop)
`define AKST_NEVER(label, cond)
`endif

`endif

// File: rtl/core/akst_pkg.sv
// Types and constants of the aging keyed slot table.
package akst_pkg;

  localparam int KIND_W     = 2;
  localparam int KEY_W      = 16;
  localparam int TIME_W     = 31;
  localparam int END_W      = 32;
  localparam int LIFE_W     = 16;
  localparam int OUT_IDX_W  = 5;
  localparam int S_TDATA_W  = 64;
  localparam int M_TDATA_W  = 24;
  localparam int S_TUSER_W  = 2;
  localparam int M_TUSER_W  = 2;
  localparam int CFG_IDX_W  = 1;

  // Beam kinds
  localparam logic [KIND_W-1:0] KIND_PARASITE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GRAPPLE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LIGHTNING = 2'd2;
  localparam logic [KIND_W-1:0] KIND_HEAT      = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_LIFETIME   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAT_NEW_LIFETIME = 1'd1;

  localparam logic [LIFE_W-1:0] NORMAL_LIFETIME_RST   = 16'd200;
  localparam logic [LIFE_W-1:0] HEAT_NEW_LIFETIME_RST = 16'd100;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture request, restart scan
    logic rd_en;   // issue one slot read at the scan counter
    logic commit;  // write the chosen slot and load the result register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last_issue;  // scan counter sits on the final slot
  } status_t;

endpackage

// File: rtl/core/akst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module akst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/akst_ctrl.sv
// Sequencer: accept, scan all slots, drain, commit and hand off the result.
module akst_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  input  akst_pkg::status_t st,
  output akst_pkg::cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid;
  logic       out_free;

  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;

  // Commands
  always_comb begin
    cmd        = '0;
    cmd.load   = (state == ST_IDLE) && s_tvalid;
    cmd.rd_en  = (state == ST_SCAN);
    cmd.commit = (state == ST_COMMIT) && out_free;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (st.last_issue) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/akst_dp.sv
// Slot storage, scan compare, slot update and result register.
module akst_dp #(
  parameter int SLOT_COUNT = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  akst_pkg::cmd_t                       cmd,
  output akst_pkg::status_t                    st,
  input  logic                                 cfg_we,
  input  logic [akst_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [akst_pkg::LIFE_W-1:0]          cfg_data,
  input  logic [akst_pkg::KIND_W-1:0]          in_kind,
  input  logic signed [akst_pkg::KEY_W-1:0]    in_src,
  input  logic signed [akst_pkg::KEY_W-1:0]    in_dst,
  input  logic [akst_pkg::TIME_W-1:0]          in_now,
  output logic [akst_pkg::OUT_IDX_W-1:0]       slot_index,
  output logic                                 was_override,
  output logic                                 overflow,
  output logic signed [akst_pkg::KEY_W-1:0]    echo_key
);

  localparam int IDX_W  = $clog2(SLOT_COUNT);
  localparam int REC_W  = akst_pkg::KEY_W + akst_pkg::END_W;

  // Lifetime registers
  logic [akst_pkg::LIFE_W-1:0] normal_lifetime;
  logic [akst_pkg::LIFE_W-1:0] heat_new_lifetime;

  always_ff @(posedge clk) begin
    if (rst) begin
      normal_lifetime   <= akst_pkg::NORMAL_LIFETIME_RST;
      heat_new_lifetime <= akst_pkg::HEAT_NEW_LIFETIME_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        akst_pkg::REG_NORMAL_LIFETIME:   normal_lifetime   <= cfg_data;
        akst_pkg::REG_HEAT_NEW_LIFETIME: heat_new_lifetime <= cfg_data;
        default: ;
      endcase
    end
  end

  // Captured request
  logic [akst_pkg::KIND_W-1:0]       req_kind;
  logic signed [akst_pkg::KEY_W-1:0] req_src;
  logic signed [akst_pkg::KEY_W-1:0] req_dst;
  logic [akst_pkg::TIME_W-1:0]       req_now;
  logic                              req_light;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_kind <= in_kind;
      req_src  <= in_src;
      req_dst  <= in_dst;
      req_now  <= in_now;
    end
  end

  assign req_light = (req_kind == akst_pkg::KIND_LIGHTNING);

  // Scan counter and read tracking
  logic [IDX_W-1:0] cnt;
  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.rd_en;
      if (cmd.load) begin
        cnt <= '0;
      end else if (cmd.rd_en) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_idx <= cnt;
    end
  end

  assign st.last_issue = (cnt == IDX_W'(SLOT_COUNT - 1));

  // Per-slot written marks; an unwritten slot reads as all zero
  logic [SLOT_COUNT-1:0] slot_valid;
  logic                  valid_rd;

  // Write side
  logic             hit_found;
  logic [IDX_W-1:0] hit_idx;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] wr_idx;
  logic             wr_en;
  logic             dst_we;
  logic [akst_pkg::KEY_W-1:0] dst_wdata;
  logic [akst_pkg::END_W-1:0] new_end;
  logic [akst_pkg::LIFE_W-1:0] life;
  logic [REC_W-1:0] rec_wdata;

  assign wr_idx   = hit_found ? hit_idx : free_idx;
  assign wr_en    = cmd.commit && (hit_found || free_found);
  assign dst_we   = wr_en && (req_light || !slot_valid[wr_idx]);
  assign dst_wdata = req_light ? req_dst : '0;
  // Overrides always use the normal lifetime; only a new heat slot is short
  assign life     = (!hit_found && req_kind == akst_pkg::KIND_HEAT) ?
                    heat_new_lifetime : normal_lifetime;
  assign new_end  = akst_pkg::END_W'(req_now) + akst_pkg::END_W'(life);
  assign rec_wdata = {req_src, new_end};

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (wr_en) begin
      slot_valid[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      valid_rd <= slot_valid[cnt];
    end
  end

  // Slot storage: source key with end time, and destination key
  logic [REC_W-1:0]           rec_rdata;
  logic [akst_pkg::KEY_W-1:0] dst_rdata;

  akst_ram #(
    .WIDTH(REC_W),
    .DEPTH(SLOT_COUNT)
  ) u_rec_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_idx),
    .wdata(rec_wdata),
    .re   (cmd.rd_en),
    .raddr(cnt),
    .rdata(rec_rdata)
  );

  akst_ram #(
    .WIDTH(akst_pkg::KEY_W),
    .DEPTH(SLOT_COUNT)
  ) u_dst_ram (
    .clk  (clk),
    .we   (dst_we),
    .waddr(wr_idx),
    .wdata(dst_wdata),
    .re   (cmd.rd_en),
    .raddr(cnt),
    .rdata(dst_rdata)
  );

  // Compare one returned slot per cycle
  logic [akst_pkg::KEY_W-1:0] eff_src;
  logic [akst_pkg::KEY_W-1:0] eff_dst;
  logic [akst_pkg::END_W-1:0] eff_end;
  logic                       match;
  logic                       expired;

  assign eff_src = valid_rd ? rec_rdata[REC_W-1 -: akst_pkg::KEY_W] : '0;
  assign eff_end = valid_rd ? rec_rdata[akst_pkg::END_W-1:0] : '0;
  assign eff_dst = valid_rd ? dst_rdata : '0;
  assign match   = (eff_src == req_src) && (!req_light || eff_dst == req_dst);
  assign expired = eff_end < akst_pkg::END_W'(req_now);

  // Keep the first hit and the first expired slot
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.load) begin
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (rd_vld) begin
      if (!hit_found && match) begin
        hit_found <= 1'b1;
      end
      if (!free_found && expired) begin
        free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld && !hit_found && match) begin
      hit_idx <= rd_idx;
    end
    if (rd_vld && !free_found && expired) begin
      free_idx <= rd_idx;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      slot_index   <= (hit_found || free_found) ? akst_pkg::OUT_IDX_W'(wr_idx) : '0;
      was_override <= hit_found;
      overflow     <= !hit_found && !free_found;
      echo_key     <= req_src;
    end
  end

endmodule

// File: rtl/core/aging_keyed_slot_table_core.sv
// Sequence: accept a request, scan the slot RAM one read per cycle, then a drain state
// and a commit state; the commit waits while the output register is still held, and a new
// request is taken only back in idle, after the previous one has committed.
// A finished result waits in its output register while the next request is taken.
// Reset (rst, synchronous): clears control, lifetimes to 200/100 and all slot marks
// at once, so every slot reads as zero right away; no clearing pass.
`include "aging_keyed_slot_table_core_assert.svh"

module aging_keyed_slot_table_core #(
  parameter int SLOT_COUNT = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  // Request stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [15:0] source_key, [31:16] dest_key, [62:32] now_time, [63] zero
  input  logic [akst_pkg::S_TDATA_W-1:0]      s_tdata,
  // [1:0] beam_kind
  input  logic [akst_pkg::S_TUSER_W-1:0]      s_tuser,
  // Result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [4:0] slot_index, [20:5] echo_key, [23:21] zero
  output logic [akst_pkg::M_TDATA_W-1:0]      m_tdata,
  // [0] was_override, [1] overflow
  output logic [akst_pkg::M_TUSER_W-1:0]      m_tuser,
  // Configuration writes
  input  logic                                cfg_we,
  input  logic [akst_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [akst_pkg::LIFE_W-1:0]         cfg_data
);

  akst_pkg::cmd_t    cmd;
  akst_pkg::status_t st;

  logic [akst_pkg::OUT_IDX_W-1:0]    slot_index;
  logic                              was_override;
  logic                              overflow;
  logic signed [akst_pkg::KEY_W-1:0] echo_key;

  akst_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .st      (st),
    .cmd     (cmd)
  );

  akst_dp #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_kind     (s_tuser[akst_pkg::KIND_W-1:0]),
    .in_src      (s_tdata[15:0]),
    .in_dst      (s_tdata[31:16]),
    .in_now      (s_tdata[62:32]),
    .slot_index  (slot_index),
    .was_override(was_override),
    .overflow    (overflow),
    .echo_key    (echo_key)
  );

  // Output packing
  assign m_tdata = {3'b000, echo_key, slot_index};
  assign m_tuser = {overflow, was_override};

  // An overflow result never names a slot or claims an override
  `AKST_ASSERT(a_ovf_clean, (m_tvalid && m_tuser[1]) |-> (m_tdata[4:0] == '0 && !m_tuser[0]))
  // A request is followed by a scan, never by a second accept
  `AKST_ASSERT(a_one_at_a_time, (s_tvalid && s_tready) |=> !s_tready)
  // A commit only happens when the result register is free
  `AKST_NEVER(a_commit_free, cmd.commit && m_tvalid && !m_tready)
  // A commit always presents a result on the next cycle
  `AKST_ASSERT(a_commit_shows, cmd.commit |=> m_tvalid)

endmodule
